/* hw/rtl/tgdm_pkg.sv */
// Shared constants, codes and types of the TeX group delimiter matcher.
package tgdm_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int INDEX_BITS  = 16;
	localparam int ENV_BITS    = 16;
	localparam int KIND_BITS   = 4;
	localparam int RES_BITS    = 4;
	localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);

	// token kinds
	localparam logic [KIND_BITS-1:0] K_OTHER  = 4'd0;
	localparam logic [KIND_BITS-1:0] K_BOPEN  = 4'd1;
	localparam logic [KIND_BITS-1:0] K_BCLOSE = 4'd2;
	localparam logic [KIND_BITS-1:0] K_SOPEN  = 4'd3;
	localparam logic [KIND_BITS-1:0] K_SCLOSE = 4'd4;
	localparam logic [KIND_BITS-1:0] K_MATH   = 4'd5;
	localparam logic [KIND_BITS-1:0] K_DMATH  = 4'd6;
	localparam logic [KIND_BITS-1:0] K_LEFT   = 4'd7;
	localparam logic [KIND_BITS-1:0] K_RIGHT  = 4'd8;
	localparam logic [KIND_BITS-1:0] K_DOPEN  = 4'd9;
	localparam logic [KIND_BITS-1:0] K_DCLOSE = 4'd10;
	localparam logic [KIND_BITS-1:0] K_BEGIN  = 4'd11;
	localparam logic [KIND_BITS-1:0] K_END    = 4'd12;

	// result kinds
	localparam logic [RES_BITS-1:0] R_PAIR      = 4'd0;
	localparam logic [RES_BITS-1:0] R_PLAIN     = 4'd1;
	localparam logic [RES_BITS-1:0] R_UNCLOSED  = 4'd2;
	localparam logic [RES_BITS-1:0] R_UNMATCHED = 4'd3;
	localparam logic [RES_BITS-1:0] R_BADARG    = 4'd4;
	localparam logic [RES_BITS-1:0] R_ENVMIS    = 4'd5;
	localparam logic [RES_BITS-1:0] R_OVERFLOW  = 4'd6;
	localparam logic [RES_BITS-1:0] R_DONE      = 4'd7;
	localparam logic [RES_BITS-1:0] R_STRAY     = 4'd8;

	// request types
	localparam logic REQ_TOKEN = 1'b0;
	localparam logic REQ_END   = 1'b1;

	// stack cell operations
	typedef logic [1:0] cell_op_t;
	localparam cell_op_t OP_HOLD = 2'd0;
	localparam cell_op_t OP_PUSH = 2'd1;
	localparam cell_op_t OP_POP  = 2'd2;

	// one open delimiter; the has_* bits say whether that math kind sits at or below it
	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [INDEX_BITS-1:0] index;
		logic [ENV_BITS-1:0]   env;
		logic                  has_math;
		logic                  has_dmath;
	} entry_t;

endpackage

/* hw/rtl/tgdm_if.sv */
// Request and result channel interfaces of the TeX group delimiter matcher.
interface tgdm_req_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic [tgdm_pkg::KIND_BITS-1:0]  token_kind;
	logic [tgdm_pkg::ENV_BITS-1:0]   env_name_id;
	logic                            env_arg_ok;

	modport source (output valid, req_type, token_kind, env_name_id, env_arg_ok,
		input ready);
	modport sink (input valid, req_type, token_kind, env_name_id, env_arg_ok,
		output ready);
endinterface

interface tgdm_res_if;
	logic                            valid;
	logic                            ready;
	logic [tgdm_pkg::RES_BITS-1:0]   result_kind;
	logic [tgdm_pkg::INDEX_BITS-1:0] first_index;
	logic [tgdm_pkg::INDEX_BITS-1:0] second_index;
	logic                            last;

	modport source (output valid, result_kind, first_index, second_index, last,
		input ready);
	modport sink (input valid, result_kind, first_index, second_index, last,
		output ready);
endinterface

/* hw/rtl/tex_group_delimiter_matcher.sv */
// Top level of the TeX group delimiter matcher: token numbering, matching control, result register.
//
// The block takes one classified TeX token (or an end-of-stream request) per request,
// numbers the tokens from 0 (wrapping at 2^INDEX_BITS) and matches closers against a
// stack of open delimiters held in a row of 32 cells that shift down on a push and up
// on a pop, cell 0 being the top. A request is first accepted and then worked in steps against
// the top of stack. Each result takes one step, so a closing brace or an end request that pops
// plain brackets takes a step for each popped bracket and a final step, and every step, with or
// without a result, waits while the single result register is still held by the sink.
// The stack needs no clearing after reset: only entries below the fill count are ever
// looked at. Each entry carries flags telling whether a $ or $$ opener lies at or below
// it, so the deep search for an unclosed math shift costs nothing. After the first error
// tokens are only counted until the end request, which also restarts numbering at zero.

module tex_group_delimiter_matcher (
	input  logic     clk,
	input  logic     arst_n,
	tgdm_req_if.sink req,
	tgdm_res_if.source res
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	localparam int IB = tgdm_pkg::INDEX_BITS;
	localparam int CB = tgdm_pkg::CNT_BITS;

	// control state
	logic          state_q;
	logic [CB-1:0] count_q;
	logic [IB-1:0] counter_q;
	logic          after_left_q;
	logic          err_q;
	logic          res_valid_q;

	// request being worked on
	logic                              cur_type_q;
	logic [tgdm_pkg::KIND_BITS-1:0]    cur_kind_q;
	logic [tgdm_pkg::ENV_BITS-1:0]     cur_env_q;
	logic                              cur_arg_q;
	logic [IB-1:0]                     cur_idx_q;
	logic                              cur_left_q;

	// result register payload
	logic [tgdm_pkg::RES_BITS-1:0] res_kind_q;
	logic [IB-1:0]                 res_first_q;
	logic [IB-1:0]                 res_second_q;
	logic                          res_last_q;

	tgdm_pkg::entry_t   top;
	tgdm_pkg::entry_t   push_entry;
	tgdm_pkg::cell_op_t step_op;
	tgdm_pkg::cell_op_t cell_op;

	logic                          accept;
	logic                          out_free;
	logic                          go;
	logic                          nonempty;
	logic                          full;
	logic [tgdm_pkg::KIND_BITS-1:0] top_kind;

	logic                          emit;
	logic [tgdm_pkg::RES_BITS-1:0] e_kind;
	logic [IB-1:0]                 e_first;
	logic [IB-1:0]                 e_second;
	logic                          e_last;
	logic                          fin;
	logic                          set_err;
	logic                          srst;
	logic                          do_push;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid & req.ready;
	assign out_free  = ~res_valid_q | res.ready;
	assign go        = (state_q == S_EXEC) & out_free;

	assign nonempty = (count_q != '0);
	assign full     = (count_q == CB'(tgdm_pkg::STACK_DEPTH));
	assign top_kind = nonempty ? top.kind : tgdm_pkg::K_OTHER;

	// new top entry; math flags fold in whatever lies below
	always_comb begin
		push_entry.kind      = cur_kind_q;
		push_entry.index     = cur_idx_q;
		push_entry.env       = cur_env_q;
		push_entry.has_math  = (cur_kind_q == tgdm_pkg::K_MATH) | (nonempty & top.has_math);
		push_entry.has_dmath = (cur_kind_q == tgdm_pkg::K_DMATH) | (nonempty & top.has_dmath);
	end

	// one step against the top of stack
	always_comb begin
		emit     = 1'b0;
		e_kind   = tgdm_pkg::R_PAIR;
		e_first  = '0;
		e_second = '0;
		e_last   = 1'b1;
		fin      = 1'b1;
		step_op  = tgdm_pkg::OP_HOLD;
		set_err  = 1'b0;
		srst     = 1'b0;
		do_push  = 1'b0;

		if (cur_type_q == tgdm_pkg::REQ_END) begin
			if (err_q) begin
				srst = 1'b1;
			end else if (top_kind == tgdm_pkg::K_SOPEN) begin
				// leftover bracket: plain, keep draining
				emit    = 1'b1;
				e_kind  = tgdm_pkg::R_PLAIN;
				e_first = top.index;
				e_last  = 1'b0;
				fin     = 1'b0;
				step_op = tgdm_pkg::OP_POP;
			end else if (nonempty) begin
				emit    = 1'b1;
				e_kind  = tgdm_pkg::R_UNCLOSED;
				e_first = top.index;
				srst    = 1'b1;
			end else begin
				emit   = 1'b1;
				e_kind = tgdm_pkg::R_DONE;
				srst   = 1'b1;
			end
		end else if (!err_q) begin
			case (cur_kind_q)
				tgdm_pkg::K_BOPEN, tgdm_pkg::K_LEFT, tgdm_pkg::K_DOPEN: begin
					do_push = 1'b1;
				end
				tgdm_pkg::K_SOPEN: begin
					if (cur_left_q) begin
						emit    = 1'b1;
						e_kind  = tgdm_pkg::R_PLAIN;
						e_first = cur_idx_q;
					end else begin
						do_push = 1'b1;
					end
				end
				tgdm_pkg::K_BCLOSE: begin
					if (top_kind == tgdm_pkg::K_SOPEN) begin
						emit    = 1'b1;
						e_kind  = tgdm_pkg::R_PLAIN;
						e_first = top.index;
						e_last  = 1'b0;
						fin     = 1'b0;
						step_op = tgdm_pkg::OP_POP;
					end else if (!nonempty) begin
						emit    = 1'b1;
						e_kind  = tgdm_pkg::R_STRAY;
						e_first = cur_idx_q;
						set_err = 1'b1;
					end else if (top_kind == tgdm_pkg::K_BOPEN) begin
						emit     = 1'b1;
						e_first  = top.index;
						e_second = cur_idx_q;
						step_op  = tgdm_pkg::OP_POP;
					end else begin
						emit    = 1'b1;
						e_kind  = tgdm_pkg::R_UNMATCHED;
						e_first = cur_idx_q;
						set_err = 1'b1;
					end
				end
				tgdm_pkg::K_SCLOSE: begin
					emit = 1'b1;
					if (top_kind == tgdm_pkg::K_SOPEN) begin
						e_first  = top.index;
						e_second = cur_idx_q;
						step_op  = tgdm_pkg::OP_POP;
					end else begin
						e_kind  = tgdm_pkg::R_PLAIN;
						e_first = cur_idx_q;
					end
				end
				tgdm_pkg::K_MATH, tgdm_pkg::K_DMATH: begin
					if (top_kind == cur_kind_q) begin
						emit     = 1'b1;
						e_first  = top.index;
						e_second = cur_idx_q;
						step_op  = tgdm_pkg::OP_POP;
					end else if (nonempty & ((cur_kind_q == tgdm_pkg::K_MATH) ?
							top.has_math : top.has_dmath)) begin
						// same shift open deeper down: report at the top opener
						emit    = 1'b1;
						e_kind  = tgdm_pkg::R_UNCLOSED;
						e_first = top.index;
						set_err = 1'b1;
					end else begin
						do_push = 1'b1;
					end
				end
				tgdm_pkg::K_BEGIN: begin
					if (!cur_arg_q) begin
						emit    = 1'b1;
						e_kind  = tgdm_pkg::R_BADARG;
						e_first = cur_idx_q;
						set_err = 1'b1;
					end else begin
						do_push = 1'b1;
					end
				end
				tgdm_pkg::K_RIGHT, tgdm_pkg::K_DCLOSE, tgdm_pkg::K_END: begin
					emit = 1'b1;
					if (top_kind != (cur_kind_q - tgdm_pkg::KIND_BITS'(1))) begin
						e_kind  = tgdm_pkg::R_UNMATCHED;
						e_first = cur_idx_q;
						set_err = 1'b1;
					end else if ((cur_kind_q == tgdm_pkg::K_END) && !cur_arg_q) begin
						e_kind  = tgdm_pkg::R_BADARG;
						e_first = cur_idx_q;
						set_err = 1'b1;
					end else if ((cur_kind_q == tgdm_pkg::K_END) && (top.env != cur_env_q)) begin
						e_kind  = tgdm_pkg::R_ENVMIS;
						e_first = cur_idx_q + IB'(2);
						set_err = 1'b1;
					end else begin
						e_first  = top.index;
						e_second = cur_idx_q;
						step_op  = tgdm_pkg::OP_POP;
					end
				end
				default: begin
				end
			endcase

			if (do_push) begin
				if (full) begin
					emit    = 1'b1;
					e_kind  = tgdm_pkg::R_OVERFLOW;
					e_first = cur_idx_q;
					set_err = 1'b1;
				end else begin
					step_op = tgdm_pkg::OP_PUSH;
				end
			end
		end
	end

	assign cell_op = go ? step_op : tgdm_pkg::OP_HOLD;

	tgdm_stack u_stack (
		.clk        (clk),
		.op         (cell_op),
		.push_entry (push_entry),
		.top        (top)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			counter_q    <= '0;
			after_left_q <= 1'b0;
			err_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= S_EXEC;
				if (req.req_type == tgdm_pkg::REQ_TOKEN) begin
					counter_q    <= counter_q + IB'(1);
					after_left_q <= (req.token_kind == tgdm_pkg::K_LEFT);
				end
			end

			if (go) begin
				if (fin) begin
					state_q <= S_IDLE;
				end
				if (srst) begin
					count_q      <= '0;
					counter_q    <= '0;
					after_left_q <= 1'b0;
					err_q        <= 1'b0;
				end else begin
					if (set_err) begin
						err_q <= 1'b1;
					end
					if (step_op == tgdm_pkg::OP_PUSH) begin
						count_q <= count_q + CB'(1);
					end else if (step_op == tgdm_pkg::OP_POP) begin
						count_q <= count_q - CB'(1);
					end
				end
			end

			if (go && emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_type_q <= req.req_type;
			cur_kind_q <= req.token_kind;
			cur_env_q  <= req.env_name_id;
			cur_arg_q  <= req.env_arg_ok;
			cur_idx_q  <= counter_q;
			cur_left_q <= after_left_q;
		end
		if (go && emit) begin
			res_kind_q   <= e_kind;
			res_first_q  <= e_first;
			res_second_q <= e_second;
			res_last_q   <= e_last;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.result_kind  = res_kind_q;
	assign res.first_index  = res_first_q;
	assign res.second_index = res_second_q;
	assign res.last         = res_last_q;

endmodule

/* hw/rtl/tgdm_cell.sv */
// One stack cell: holds an entry, loads from the cell above on push, below on pop.
module tgdm_cell (
	input  logic               clk,
	input  tgdm_pkg::cell_op_t op,
	input  tgdm_pkg::entry_t   above,
	input  tgdm_pkg::entry_t   below,
	output tgdm_pkg::entry_t   entry
);

	tgdm_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		case (op)
			tgdm_pkg::OP_PUSH: entry_q <= above;
			tgdm_pkg::OP_POP:  entry_q <= below;
			default:           entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;

endmodule

/* hw/rtl/tgdm_stack.sv */
// Row of stack cells; cell 0 is the top of stack.
module tgdm_stack (
	input  logic               clk,
	input  tgdm_pkg::cell_op_t op,
	input  tgdm_pkg::entry_t   push_entry,
	output tgdm_pkg::entry_t   top
);

	tgdm_pkg::entry_t cell_out [tgdm_pkg::STACK_DEPTH];

	for (genvar i = 0; i < tgdm_pkg::STACK_DEPTH; i++) begin : g_cell
		tgdm_pkg::entry_t above;
		tgdm_pkg::entry_t below;

		if (i == 0) begin : g_first
			assign above = push_entry;
		end else begin : g_mid
			assign above = cell_out[i-1];
		end

		if (i == tgdm_pkg::STACK_DEPTH - 1) begin : g_bottom
			assign below = '0;
		end else begin : g_upper
			assign below = cell_out[i+1];
		end

		tgdm_cell u_cell (
			.clk   (clk),
			.op    (op),
			.above (above),
			.below (below),
			.entry (cell_out[i])
		);
	end

	assign top = cell_out[0];

endmodule
